// ===== rtl/core/ofi_pkg.sv =====
package ofi_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam logic [31:0] CordicGain  = 32'h26DD3B6A;
  localparam logic [31:0] InvTwoPi    = 32'd683565276;
  localparam logic [23:0] VelMaxMag   = 24'h800000;

  localparam logic [1:0] CfgStartMarker  = 2'd0;
  localparam logic [1:0] CfgEndMarker    = 2'd1;
  localparam logic [1:0] CfgVelocityLimit = 2'd2;

  typedef struct packed {
    logic [7:0]  frame_head;
    logic [7:0]  lin_byte0;
    logic [7:0]  lin_byte1;
    logic [7:0]  lin_byte2;
    logic [7:0]  lin_byte3;
    logic [7:0]  ang_byte0;
    logic [7:0]  ang_byte1;
    logic [7:0]  ang_byte2;
    logic [7:0]  ang_byte3;
    logic [7:0]  frame_tail;
    logic [15:0] elapsed_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [23:0] lin_velocity;
    logic signed [23:0] ang_velocity;
    logic               frame_accepted;
  } out_t;

  typedef struct packed {
    logic               ok;
    logic signed [23:0] lin;
    logic signed [23:0] ang;
    logic [15:0]        dt;
  } job_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [22:0] velocity_limit;
  } cfg_t;

  function automatic logic [31:0] atan_entry(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'h20000000;
      4'd1:    r = 32'h12E4051E;
      4'd2:    r = 32'h09FB385B;
      4'd3:    r = 32'h051111D4;
      4'd4:    r = 32'h028B0D43;
      4'd5:    r = 32'h0145D7E1;
      4'd6:    r = 32'h00A2F61E;
      4'd7:    r = 32'h00517C55;
      4'd8:    r = 32'h0028BE53;
      4'd9:    r = 32'h00145F2F;
      4'd10:   r = 32'h000A2F98;
      4'd11:   r = 32'h000517CC;
      4'd12:   r = 32'h00028BE6;
      4'd13:   r = 32'h000145F3;
      4'd14:   r = 32'h0000A2F9;
      4'd15:   r = 32'h0000517C;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] lim_apply(input logic [23:0] mag, input logic neg,
                                                   input logic [22:0] limit);
    logic signed [23:0] r;
    if (mag >= {1'b0, limit}) begin
      r = '0;
    end else if (neg) begin
      r = -$signed(mag);
    end else begin
      r = $signed(mag);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ofi_front.sv =====
module ofi_front (
  input  ofi_pkg::in_t  req_i,
  input  ofi_pkg::cfg_t cfg_i,
  output ofi_pkg::job_t job_o
);
  import ofi_pkg::*;

  function automatic logic [23:0] float_mag(input logic [31:0] b);
    logic [7:0]  ex;
    logic [23:0] sig;
    logic [7:0]  sh;
    logic [23:0] r;
    ex  = b[30:23];
    sig = {1'b1, b[22:0]};
    sh  = 8'd134 - ex;
    if (ex == 8'hFF || ex >= 8'd134) begin
      r = VelMaxMag;
    end else if (ex == 8'd0 || sh >= 8'd24) begin
      r = '0;
    end else begin
      r = sig >> sh[4:0];
    end
    return r;
  endfunction

  logic [31:0] lin_bits;
  logic [31:0] ang_bits;

  assign lin_bits = {req_i.lin_byte3, req_i.lin_byte2, req_i.lin_byte1, req_i.lin_byte0};
  assign ang_bits = {req_i.ang_byte3, req_i.ang_byte2, req_i.ang_byte1, req_i.ang_byte0};

  assign job_o.ok  = (req_i.frame_head == cfg_i.start_marker) &&
                     (req_i.frame_tail == cfg_i.end_marker);
  assign job_o.lin = lim_apply(float_mag(lin_bits), lin_bits[31], cfg_i.velocity_limit);
  assign job_o.ang = lim_apply(float_mag(ang_bits), ang_bits[31], cfg_i.velocity_limit);
  assign job_o.dt  = req_i.elapsed_time;

endmodule

// ===== rtl/core/ofi_queue.sv =====
module ofi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ofi_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output ofi_pkg::job_t pop_data_o
);
  import ofi_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign avail_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/ofi_back.sv =====
module ofi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [22:0]   limit_i,
  input  logic          avail_i,
  input  ofi_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ofi_pkg::out_t out_rsp_o
);
  import ofi_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRot  = 3'd1;
  localparam logic [2:0] SMul1 = 3'd2;
  localparam logic [2:0] SMul2 = 3'd3;
  localparam logic [2:0] SUpd  = 3'd4;

  logic [2:0]         st_q, st_d;
  logic [3:0]         it_q, it_d;
  logic signed [31:0] x_q, x_d, y_q, y_d;
  logic [31:0]        h_q, h_d;
  logic signed [23:0] lv_q, lv_d, av_q, av_d;
  logic               ok_q, ok_d, flip_q, flip_d;
  logic [15:0]        dt_q, dt_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [57:0] mc_q, mc_d, ms_q, ms_d, mh_q, mh_d;
  logic signed [57:0] pc_q, pc_d, ps_q, ps_d, ph_q, ph_d;
  logic               ov_q, ov_d;
  out_t               out_q, out_d;

  logic signed [23:0] lsel, asel;
  logic [31:0]        ang;
  logic signed [33:0] xs, ys, at;
  logic signed [17:0] dts;
  logic signed [33:0] csel, ssel;
  logic signed [25:0] pcs, pss;
  logic signed [39:0] phs;
  logic signed [43:0] sx, sy;
  logic signed [31:0] nx, ny;

  function automatic logic signed [23:0] lim_reg(input logic signed [23:0] v,
                                                 input logic [22:0] limit);
    logic [23:0] mag;
    mag = v[23] ? 24'(-v) : 24'(v);
    return lim_apply(mag, v[23], limit);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] s);
    logic signed [31:0] r;
    if (s > 44'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (s < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  assign pop_o       = (st_q == SIdle) && avail_i;
  assign out_valid_o = ov_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    st_d = st_q; it_d = it_q;
    x_d = x_q; y_d = y_q; h_d = h_q; lv_d = lv_q; av_d = av_q;
    ok_d = ok_q; flip_d = flip_q; dt_d = dt_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    mc_d = mc_q; ms_d = ms_q; mh_d = mh_q;
    pc_d = pc_q; ps_d = ps_q; ph_d = ph_q;
    out_d = out_q;
    ov_d = ov_q && out_stall_i;

    lsel = job_i.ok ? job_i.lin : lv_q;
    asel = job_i.ok ? job_i.ang : av_q;
    ang  = h_q;
    if (h_q[31:30] == 2'b01 || h_q[31:30] == 2'b10) begin
      ang = h_q + 32'h80000000;
    end
    xs   = cx_q >>> it_q;
    ys   = cy_q >>> it_q;
    at   = $signed({2'b00, atan_entry(it_q)});
    dts  = $signed({2'b00, dt_q});
    csel = flip_q ? -cx_q : cx_q;
    ssel = flip_q ? -cy_q : cy_q;
    pcs  = 26'(mc_q >>> 30);
    pss  = 26'(ms_q >>> 30);
    phs  = 40'(mh_q >>> 16);
    sx   = 44'(x_q) + 44'(pc_q >>> 16);
    sy   = 44'(y_q) + 44'(ps_q >>> 16);
    nx   = sat32(sx);
    ny   = sat32(sy);

    case (st_q)
      SIdle: begin
        if (avail_i) begin
          ok_d   = job_i.ok;
          dt_d   = job_i.dt;
          lv_d   = lim_reg(lsel, limit_i);
          av_d   = lim_reg(asel, limit_i);
          flip_d = h_q[31:30] == 2'b01 || h_q[31:30] == 2'b10;
          cx_d   = $signed({2'b00, CordicGain});
          cy_d   = '0;
          cz_d   = 34'($signed(ang));
          it_d   = '0;
          st_d   = SRot;
        end
      end
      SRot: begin
        if (!cz_q[33]) begin
          cx_d = cx_q - ys; cy_d = cy_q + xs; cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + ys; cy_d = cy_q - xs; cz_d = cz_q + at;
        end
        it_d = it_q + 4'd1;
        if (it_q == 4'(CordicSteps - 1)) begin
          st_d = SMul1;
        end
      end
      SMul1: begin
        mc_d = 58'(lv_q * csel);
        ms_d = 58'(lv_q * ssel);
        mh_d = 58'(lv_q * 0) + 58'(av_q * $signed({1'b0, InvTwoPi}));
        st_d = SMul2;
      end
      SMul2: begin
        pc_d = 58'(pcs * dts);
        ps_d = 58'(pss * dts);
        ph_d = 58'(phs * dts);
        st_d = SUpd;
      end
      SUpd: begin
        if (!ov_q || !out_stall_i) begin
          x_d   = nx;
          y_d   = ny;
          h_d   = h_q + ph_q[47:16];
          out_d = '{pos_x: nx, pos_y: ny, heading: h_q + ph_q[47:16],
                    lin_velocity: lv_q, ang_velocity: av_q, frame_accepted: ok_q};
          ov_d  = 1'b1;
          st_d  = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      ov_q <= 1'b0;
      x_q  <= '0;
      y_q  <= '0;
      h_q  <= '0;
      lv_q <= '0;
      av_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      x_q  <= x_d;
      y_q  <= y_d;
      h_q  <= h_d;
      lv_q <= lv_d;
      av_q <= av_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; ok_q <= ok_d; flip_q <= flip_d; dt_q <= dt_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    mc_q <= mc_d; ms_q <= ms_d; mh_q <= mh_d;
    pc_q <= pc_d; ps_q <= ps_d; ph_q <= ph_d;
    out_q <= out_d;
  end

endmodule

// ===== rtl/core/odometry_frame_integrator_unit.sv =====
// flow: an accepted request is popped from the queue by the idle back end, then passes the
//   16-step cordic loop, the two multiply stages and the update state, which can wait on out_stall_i;
//   a new request is taken only once the back end is idle again; a 2-entry queue sits in front
// reset: pose, velocities and queue clear, registers return to 0xff, 0xfe and
//   327680; no clearing pass
module odometry_frame_integrator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ofi_pkg::in_t   in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ofi_pkg::out_t  out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [22:0]    cfg_data_i
);
  import ofi_pkg::*;

  cfg_t cfg_q, cfg_d;
  job_t fjob, qjob;
  logic full, avail, pop, push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartMarker:   cfg_d.start_marker   = cfg_data_i[7:0];
        CfgEndMarker:     cfg_d.end_marker     = cfg_data_i[7:0];
        CfgVelocityLimit: cfg_d.velocity_limit = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_marker: 8'hFF, end_marker: 8'hFE, velocity_limit: 23'd327680};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ofi_front u_front (
    .req_i (in_req_i),
    .cfg_i (cfg_q),
    .job_o (fjob)
  );

  ofi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (fjob),
    .full_o      (full),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (qjob)
  );

  ofi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (cfg_q.velocity_limit),
    .avail_i     (avail),
    .job_i       (qjob),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
